FILE: hw/rtl/greedy_line_wrapper_assert.svh
// Assertion macros used by the checker file.
`ifndef GREEDY_LINE_WRAPPER_ASSERT_SVH
`define GREEDY_LINE_WRAPPER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GLW_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define GLW_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/glw_pkg.sv
package glw_pkg;

	// Default sizes of offsets/counters and of width accumulators
	localparam int OFFSET_BITS_DEF = 16;
	localparam int WIDTH_BITS_DEF  = 24;

	// Fixed field widths
	localparam int ADVANCE_BITS = 22;
	localparam int BREAK_BITS   = 2;

	// Item operation codes
	localparam logic OP_GLYPH = 1'b0;
	localparam logic OP_END   = 1'b1;

	// Break classes of the byte before a cluster
	localparam logic [BREAK_BITS-1:0] BRK_NONE      = 2'd0;
	localparam logic [BREAK_BITS-1:0] BRK_ALLOWED   = 2'd1;
	localparam logic [BREAK_BITS-1:0] BRK_MANDATORY = 2'd2;

	// Handshake state of the item register, passed to the output register
	typedef struct packed {
		logic fire;      // item leaves the input register this cycle
		logic emit;      // item closes a line
	} glw_flow_t;

endpackage

FILE: hw/rtl/glw_if.sv
interface glw_glyph_if #(
	parameter int OFFSET_BITS = glw_pkg::OFFSET_BITS_DEF
);
	import glw_pkg::*;

	logic                    valid;
	logic                    ready;
	logic                    operation;
	logic [OFFSET_BITS-1:0]  cluster;
	logic [BREAK_BITS-1:0]   break_before;
	logic [ADVANCE_BITS-1:0] advance;

	modport source (output valid, operation, cluster, break_before, advance, input ready);
	modport sink (input valid, operation, cluster, break_before, advance, output ready);
endinterface

interface glw_line_if #(
	parameter int OFFSET_BITS = glw_pkg::OFFSET_BITS_DEF,
	parameter int WIDTH_BITS  = glw_pkg::WIDTH_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [OFFSET_BITS-1:0] first_glyph;
	logic [OFFSET_BITS-1:0] glyph_count;
	logic [OFFSET_BITS-1:0] byte_offset;
	logic [OFFSET_BITS-1:0] byte_length;
	logic [WIDTH_BITS-1:0]  line_width;
	logic                   final_line;

	modport source (output valid, first_glyph, glyph_count, byte_offset, byte_length,
		line_width, final_line, input ready);
	modport sink (input valid, first_glyph, glyph_count, byte_offset, byte_length,
		line_width, final_line, output ready);
endinterface

FILE: hw/rtl/glw_in_stage.sv
module glw_in_stage #(
	parameter int OFFSET_BITS = glw_pkg::OFFSET_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	glw_glyph_if.sink                        glyphs,
	input  logic                             fire,
	output logic                             valid_s1,
	output logic                             operation_s1,
	output logic [OFFSET_BITS-1:0]           cluster_s1,
	output logic [glw_pkg::BREAK_BITS-1:0]   break_before_s1,
	output logic [glw_pkg::ADVANCE_BITS-1:0] advance_s1
);
	import glw_pkg::*;

	logic take;

	// Accept when empty or when the held item moves on this cycle
	assign glyphs.ready = !valid_s1 || fire;
	assign take         = glyphs.valid && glyphs.ready;

	// Track occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the payload on each transfer
	always_ff @(posedge clk) begin
		if (take) begin
			operation_s1    <= glyphs.operation;
			cluster_s1      <= glyphs.cluster;
			break_before_s1 <= glyphs.break_before;
			advance_s1      <= glyphs.advance;
		end
	end
endmodule

FILE: hw/rtl/glw_core.sv
module glw_core #(
	parameter int OFFSET_BITS = glw_pkg::OFFSET_BITS_DEF,
	parameter int WIDTH_BITS  = glw_pkg::WIDTH_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             fire,
	input  logic                             operation,
	input  logic [OFFSET_BITS-1:0]           cluster,
	input  logic [glw_pkg::BREAK_BITS-1:0]   break_before,
	input  logic [glw_pkg::ADVANCE_BITS-1:0] advance,
	input  logic                             cfg_we,
	input  logic [WIDTH_BITS-1:0]            cfg_wdata,
	output logic                             emit,
	output logic [OFFSET_BITS-1:0]           first_glyph,
	output logic [OFFSET_BITS-1:0]           glyph_count,
	output logic [OFFSET_BITS-1:0]           byte_offset,
	output logic [OFFSET_BITS-1:0]           byte_length,
	output logic [WIDTH_BITS-1:0]            line_width,
	output logic                             final_line
);
	import glw_pkg::*;

	localparam int SUM_BITS = ((WIDTH_BITS > ADVANCE_BITS) ? WIDTH_BITS : ADVANCE_BITS) + 1;
	localparam logic [WIDTH_BITS-1:0] WID_MAX = {WIDTH_BITS{1'b1}};

	// Line state
	logic [WIDTH_BITS-1:0]  wrap_width_q;
	logic [OFFSET_BITS-1:0] glyph_counter_q;
	logic [OFFSET_BITS-1:0] line_start_glyph_q;
	logic [OFFSET_BITS-1:0] line_start_byte_q;
	logic [WIDTH_BITS-1:0]  running_width_q;
	logic [OFFSET_BITS-1:0] break_glyph_q;
	logic [OFFSET_BITS-1:0] break_byte_q;
	logic [WIDTH_BITS-1:0]  width_at_break_q;
	logic                   break_pending_q;

	// Next state
	logic [OFFSET_BITS-1:0] ls_glyph_d;
	logic [OFFSET_BITS-1:0] ls_byte_d;
	logic [WIDTH_BITS-1:0]  run_d;
	logic [OFFSET_BITS-1:0] brk_glyph_d;
	logic [OFFSET_BITS-1:0] brk_byte_d;
	logic [WIDTH_BITS-1:0]  brk_width_d;
	logic                   pending_d;

	logic                   is_end;
	logic                   past_start;
	logic                   mandatory;
	logic                   allowed;
	logic [WIDTH_BITS-1:0]  run_base;
	logic [SUM_BITS-1:0]    adv_x;
	logic [SUM_BITS-1:0]    sum;
	logic [WIDTH_BITS-1:0]  run_sat;
	logic                   wrap;

	assign is_end     = (operation == OP_END);
	assign past_start = (cluster > line_start_byte_q);

	// Decode the break class; the unused code counts as none
	always_comb begin
		mandatory = 1'b0;
		allowed   = 1'b0;
		case (break_before)
			BRK_MANDATORY: mandatory = past_start;
			BRK_ALLOWED:   allowed   = past_start;
			BRK_NONE:      ;
			default:       ;
		endcase
	end

	// Mandatory break restarts the width; then add the advance, saturating
	assign run_base = mandatory ? '0 : running_width_q;
	assign adv_x    = SUM_BITS'(advance) & SUM_BITS'(WID_MAX);
	assign sum      = SUM_BITS'(run_base) + adv_x;
	assign run_sat  = (|sum[SUM_BITS-1:WIDTH_BITS]) ? WID_MAX : sum[WIDTH_BITS-1:0];

	// Record the break point seen at this glyph
	assign brk_glyph_d = allowed ? glyph_counter_q : break_glyph_q;
	assign brk_byte_d  = allowed ? cluster : break_byte_q;
	assign brk_width_d = allowed ? running_width_q : width_at_break_q;

	// Wrap at the pending break once the width passes the limit
	assign wrap = (wrap_width_q != '0) && (run_sat > wrap_width_q)
		&& !mandatory && (allowed || break_pending_q);

	// Line start, width and pending flag after this glyph
	always_comb begin
		ls_glyph_d = line_start_glyph_q;
		ls_byte_d  = line_start_byte_q;
		run_d      = run_sat;
		pending_d  = break_pending_q || allowed;
		if (mandatory) begin
			ls_glyph_d = glyph_counter_q;
			ls_byte_d  = cluster;
			pending_d  = 1'b0;
		end
		if (wrap) begin
			ls_glyph_d = brk_glyph_d;
			ls_byte_d  = brk_byte_d;
			run_d      = (run_sat >= brk_width_d) ? run_sat - brk_width_d : '0;
			pending_d  = 1'b0;
		end
	end

	// Form the closed line
	always_comb begin
		emit        = is_end || mandatory || wrap;
		first_glyph = line_start_glyph_q;
		byte_offset = line_start_byte_q;
		final_line  = is_end;
		if (!is_end && wrap) begin
			glyph_count = brk_glyph_d - line_start_glyph_q;
			byte_length = brk_byte_d - line_start_byte_q;
			line_width  = brk_width_d;
		end else begin
			glyph_count = glyph_counter_q - line_start_glyph_q;
			byte_length = cluster - line_start_byte_q;
			line_width  = running_width_q;
		end
	end

	// Wrap limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_width_q <= '0;
		end else if (cfg_we) begin
			wrap_width_q <= cfg_wdata;
		end
	end

	// Advance the state; an end item clears it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_counter_q    <= '0;
			line_start_glyph_q <= '0;
			line_start_byte_q  <= '0;
			running_width_q    <= '0;
			break_glyph_q      <= '0;
			break_byte_q       <= '0;
			width_at_break_q   <= '0;
			break_pending_q    <= 1'b0;
		end else if (fire) begin
			if (is_end) begin
				glyph_counter_q    <= '0;
				line_start_glyph_q <= '0;
				line_start_byte_q  <= '0;
				running_width_q    <= '0;
				break_glyph_q      <= '0;
				break_byte_q       <= '0;
				width_at_break_q   <= '0;
				break_pending_q    <= 1'b0;
			end else begin
				glyph_counter_q    <= glyph_counter_q + 1'b1;
				line_start_glyph_q <= ls_glyph_d;
				line_start_byte_q  <= ls_byte_d;
				running_width_q    <= run_d;
				break_glyph_q      <= brk_glyph_d;
				break_byte_q       <= brk_byte_d;
				width_at_break_q   <= brk_width_d;
				break_pending_q    <= pending_d;
			end
		end
	end
endmodule

FILE: hw/rtl/glw_out_reg.sv
module glw_out_reg #(
	parameter int OFFSET_BITS = glw_pkg::OFFSET_BITS_DEF,
	parameter int WIDTH_BITS  = glw_pkg::WIDTH_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  glw_pkg::glw_flow_t     flow,
	input  logic [OFFSET_BITS-1:0] first_glyph,
	input  logic [OFFSET_BITS-1:0] glyph_count,
	input  logic [OFFSET_BITS-1:0] byte_offset,
	input  logic [OFFSET_BITS-1:0] byte_length,
	input  logic [WIDTH_BITS-1:0]  line_width,
	input  logic                   final_line,
	glw_line_if.source             lines
);
	import glw_pkg::*;

	logic valid_q;

	assign lines.valid = valid_q;

	// Hold a result until its transfer; refill on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (flow.fire) begin
			valid_q <= flow.emit;
		end else if (lines.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the line fields
	always_ff @(posedge clk) begin
		if (flow.fire && flow.emit) begin
			lines.first_glyph <= first_glyph;
			lines.glyph_count <= glyph_count;
			lines.byte_offset <= byte_offset;
			lines.byte_length <= byte_length;
			lines.line_width  <= line_width;
			lines.final_line  <= final_line;
		end
	end
endmodule

FILE: hw/rtl/greedy_line_wrapper.sv
// Channel   Dir  Carries
// glyphs    in   operation, cluster, break_before, advance
// lines     out  first_glyph, glyph_count, byte_offset, byte_length, line_width, final_line
// cfg       in   cfg_we / cfg_wdata: wrap_width, 18.6 fixed point, 0 = no wrapping
//
// One item per cycle unless a line waits at the output; lines come from the output register.
// The input register feeds the break logic and line state, which load the
// output register in one pass; the state loop (width add, compares) sets the rate.
// Reset clears the line state and the wrap limit; an end item clears the state only.
// A line waiting at the output stalls the input register, which still takes one more item.
module greedy_line_wrapper #(
	parameter int OFFSET_BITS = glw_pkg::OFFSET_BITS_DEF,
	parameter int WIDTH_BITS  = glw_pkg::WIDTH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	glw_glyph_if.sink             glyphs,
	glw_line_if.source            lines,
	input  logic                  cfg_we,
	input  logic [WIDTH_BITS-1:0] cfg_wdata
);
	import glw_pkg::*;

	glw_flow_t              flow;
	logic                   valid_s1;
	logic                   operation_s1;
	logic [OFFSET_BITS-1:0] cluster_s1;
	logic [BREAK_BITS-1:0]  break_before_s1;
	logic [ADVANCE_BITS-1:0] advance_s1;
	logic                   emit;
	logic [OFFSET_BITS-1:0] first_glyph;
	logic [OFFSET_BITS-1:0] glyph_count;
	logic [OFFSET_BITS-1:0] byte_offset;
	logic [OFFSET_BITS-1:0] byte_length;
	logic [WIDTH_BITS-1:0]  line_width;
	logic                   final_line;

	// Move the held item on when the output slot is free or drains now
	assign flow.fire = valid_s1 && (!lines.valid || lines.ready);
	assign flow.emit = emit;

	glw_in_stage #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_in_stage (
		.clk            (clk),
		.arst_n         (arst_n),
		.glyphs         (glyphs),
		.fire           (flow.fire),
		.valid_s1       (valid_s1),
		.operation_s1   (operation_s1),
		.cluster_s1     (cluster_s1),
		.break_before_s1(break_before_s1),
		.advance_s1     (advance_s1)
	);

	glw_core #(
		.OFFSET_BITS(OFFSET_BITS),
		.WIDTH_BITS (WIDTH_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (flow.fire),
		.operation   (operation_s1),
		.cluster     (cluster_s1),
		.break_before(break_before_s1),
		.advance     (advance_s1),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.emit        (emit),
		.first_glyph (first_glyph),
		.glyph_count (glyph_count),
		.byte_offset (byte_offset),
		.byte_length (byte_length),
		.line_width  (line_width),
		.final_line  (final_line)
	);

	glw_out_reg #(
		.OFFSET_BITS(OFFSET_BITS),
		.WIDTH_BITS (WIDTH_BITS)
	) u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.flow       (flow),
		.first_glyph(first_glyph),
		.glyph_count(glyph_count),
		.byte_offset(byte_offset),
		.byte_length(byte_length),
		.line_width (line_width),
		.final_line (final_line),
		.lines      (lines)
	);
endmodule

FILE: hw/rtl/glw_checker.sv
`include "greedy_line_wrapper_assert.svh"

module glw_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_op,
	input logic out_valid,
	input logic out_ready,
	input logic out_final
);
	import glw_pkg::*;

	// Keep a stalled line on the port
	`GLW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "line dropped while stalled")

	// An end item yields a final line once it has left the input register and the output drains
	`GLW_ASSERT_NEXT(a_end_line, (in_valid && in_ready && in_op == OP_END) ##1 out_ready, out_valid && out_final, "end item gave no final line")

	// A line appearing on an idle output comes from an earlier input transfer
	`GLW_ASSERT_SAME(a_line_source, $rose(out_valid), $past(in_valid && in_ready, 2), "line without an input transfer")
endmodule

bind greedy_line_wrapper glw_checker u_glw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (glyphs.valid),
	.in_ready (glyphs.ready),
	.in_op    (glyphs.operation),
	.out_valid(lines.valid),
	.out_ready(lines.ready),
	.out_final(lines.final_line)
);
